>>> rtl/core/visr_pkg.sv
// Package for the importance split and roulette block.
// Holds item kinds, result actions and shared command/status types.
`default_nettype none
package visr_pkg;
	localparam int WeightW = 32;
	localparam int ValW = 32;
	localparam int RndW = 24;
	localparam int CrdW = 6;

	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_CROSS = 2'd1,
		KIND_OTHER = 2'd2,
		KIND_SPARE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ACT_SAME = 2'd0,
		ACT_PARENT = 2'd1,
		ACT_KILL = 2'd2,
		ACT_COPY = 2'd3
	} act_t;

	localparam logic [0:0] REG_COUNT_Y = 1'b0;
	localparam logic [0:0] REG_COUNT_Z = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;    // latch the input word
		logic idx_calc;   // compute both voxel indexes
		logic rd_pre;     // issue table read for pre voxel
		logic rd_post;    // issue table read for post voxel
		logic lat_pre;    // latch pre read data
		logic lat_post;   // latch post read data
		logic div_start;  // start the divider with operands chosen by div_sel
		logic [1:0] div_sel; // 0 post/pre, 1 weight/n, 2 weight*pre/post
		logic mul_start;  // form 64-bit products
		logic lat_n;      // latch split count from quotient
		logic lat_w;      // latch weight from quotient
	} visr_cmd_t;

	localparam logic [1:0] DIV_RATIO = 2'd0;
	localparam logic [1:0] DIV_SPLIT = 2'd1;
	localparam logic [1:0] DIV_SURV = 2'd2;

	typedef struct packed {
		logic div_done;
		logic pre_zero;
		logic post_gt;
		logic kill;
		logic post_zero;
		logic clearing;   // table clearing pass after reset is running
	} visr_sts_t;
endpackage
`default_nettype wire

>>> rtl/core/visr_div.sv
// Restoring radix-2 divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on no other file.
`default_nettype none
module visr_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [63:0] dividend,
	input wire logic [31:0] divisor,
	output logic done,
	output logic [63:0] quotient
);
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic [31:0] dvs_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q[31:0], quo_q[63]};
	assign trial = shifted - {1'b0, dvs_q};
	assign quotient = quo_q;
	assign done = busy_q && (cnt_q == 7'd0);

	// One quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= 7'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 7'd64;
		end else if (busy_q && cnt_q != 7'd0) begin
			cnt_q <= cnt_q - 7'd1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= 33'd0;
			dvs_q <= divisor;
		end else if (busy_q && cnt_q != 7'd0) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/visr_dp.sv
// Datapath: importance table, index arithmetic, products, divider, result fields.
// Depends on visr_pkg and visr_div.
`default_nettype none
module visr_dp import visr_pkg::*; #(
	parameter int TABLE_DEPTH = 4096,
	parameter int MAX_SPLIT = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire visr_cmd_t cmd,
	output visr_sts_t sts,
	input wire logic [6:0] cy,
	input wire logic [6:0] cz,
	input wire logic tbl_we,
	input wire logic [11:0] entry_index,
	input wire logic [ValW-1:0] entry_value,
	input wire logic [CrdW-1:0] pre_x,
	input wire logic [CrdW-1:0] pre_y,
	input wire logic [CrdW-1:0] pre_z,
	input wire logic [CrdW-1:0] post_x,
	input wire logic [CrdW-1:0] post_y,
	input wire logic [CrdW-1:0] post_z,
	input wire logic [WeightW-1:0] weight,
	input wire logic [RndW-1:0] random,
	output logic [6:0] split_n,
	output logic [WeightW-1:0] weight_in,
	output logic [WeightW-1:0] res_w
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int NW = $clog2(MAX_SPLIT + 1);
	localparam logic [AW:0] CLR_END = (AW + 1)'(TABLE_DEPTH);

	logic [ValW-1:0] mem [TABLE_DEPTH];
	logic [ValW-1:0] rd_q;
	logic [ValW-1:0] pre_q, post_q;
	logic [CrdW-1:0] px_q, py_q, pz_q, qx_q, qy_q, qz_q;
	logic [WeightW-1:0] w_q;
	logic [RndW-1:0] rnd_q;
	logic [13:0] czy_q;
	logic [20:0] pidx_q, qidx_q;
	logic [63:0] rp_q, pq_q, wp_q;
	logic [NW-1:0] n_q;
	logic [WeightW-1:0] res_q;
	logic [63:0] dvd;
	logic [31:0] dvs;
	logic dv_done;
	logic [63:0] quo;
	logic [20:0] rd_idx;
	logic [19:0] ent_ext;
	logic [AW:0] clr_q;
	logic clearing;

	// Clearing pass after reset: one table entry is zeroed per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clr_q != CLR_END) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign clearing = (clr_q != CLR_END);
	assign ent_ext = {8'd0, entry_index};

	// Table write for clearing and load items, registered read.
	always_ff @(posedge clk) begin
		if (clearing)
			mem[clr_q[AW-1:0]] <= '0;
		else if (tbl_we && ent_ext < 20'(TABLE_DEPTH))
			mem[ent_ext[AW-1:0]] <= entry_value;
		rd_q <= mem[rd_idx[AW-1:0]];
	end

	assign rd_idx = cmd.rd_pre ? pidx_q : qidx_q;

	// Input capture, index math (products of narrow values), read latches, products, split count, result weight.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q <= pre_x; py_q <= pre_y; pz_q <= pre_z;
			qx_q <= post_x; qy_q <= post_y; qz_q <= post_z;
			w_q <= weight; rnd_q <= random;
			czy_q <= cy * cz;
		end
		if (cmd.idx_calc) begin
			pidx_q <= 21'(px_q * czy_q) + 21'(py_q * cz) + 21'(pz_q);
			qidx_q <= 21'(qx_q * czy_q) + 21'(qy_q * cz) + 21'(qz_q);
		end
		if (cmd.lat_pre)
			pre_q <= (pidx_q < 21'(TABLE_DEPTH)) ? rd_q : '0;
		if (cmd.lat_post)
			post_q <= (qidx_q < 21'(TABLE_DEPTH)) ? rd_q : '0;
		if (cmd.mul_start) begin
			rp_q <= 64'(rnd_q) * 64'(pre_q);
			pq_q <= {post_q, 24'd0};
			wp_q <= 64'(w_q) * 64'(pre_q);
		end
		// A surviving track gives a single word, so the count starts at one.
		if (cmd.capture)
			n_q <= NW'(1);
		else if (cmd.lat_n)
			n_q <= (quo > 64'(MAX_SPLIT)) ? NW'(MAX_SPLIT) : NW'(quo);
		if (cmd.lat_w)
			res_q <= (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
	end

	// Divider operand selection.
	always_comb begin
		case (cmd.div_sel)
			DIV_RATIO: begin dvd = 64'(post_q); dvs = pre_q; end
			DIV_SPLIT: begin dvd = 64'(w_q); dvs = 32'(n_q); end
			default: begin dvd = wp_q; dvs = post_q; end
		endcase
	end

	visr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(dvd), .divisor(dvs), .done(dv_done), .quotient(quo)
	);

	assign sts.div_done = dv_done;
	assign sts.pre_zero = (pre_q == '0);
	assign sts.post_gt = (post_q > pre_q);
	assign sts.kill = (rp_q[55:0] > pq_q[55:0]);
	assign sts.post_zero = (post_q == '0);
	assign sts.clearing = clearing;
	assign split_n = 7'(n_q);
	assign weight_in = w_q;
	assign res_w = res_q;
endmodule
`default_nettype wire

>>> rtl/core/visr_ctrl.sv
// Controller state machine: sequences lookups, divisions and result words.
// Depends on visr_pkg.
`default_nettype none
module visr_ctrl import visr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] in_kind,
	output visr_cmd_t cmd,
	input wire visr_sts_t sts,
	input wire logic [6:0] split_n,
	input wire logic [WeightW-1:0] weight_in,
	input wire logic [WeightW-1:0] res_w,
	output logic tbl_we,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] action,
	output logic [WeightW-1:0] new_weight,
	output logic last
);
	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_IDX  = 11'b00000000010,
		S_RDP  = 11'b00000000100,
		S_RDQ  = 11'b00000001000,
		S_LATQ = 11'b00000010000,
		S_DEC  = 11'b00000100000,
		S_DIVR = 11'b00001000000,
		S_DIVS = 11'b00010000000,
		S_DIVW = 11'b00100000000,
		S_EMIT = 11'b01000000000,
		S_WAIT = 11'b10000000000
	} state_t;

	state_t st_q, st_d;
	logic [6:0] cnt_q;
	logic ov_q;
	logic [1:0] act_q;
	logic [WeightW-1:0] w_q;
	logic last_q;
	logic take;
	logic o_free;
	logic emit;
	logic [1:0] e_act;
	logic [WeightW-1:0] e_w;
	logic e_last;

	assign take = in_valid && !in_stall;
	assign o_free = !ov_q || !out_stall;
	assign in_stall = (st_q != S_IDLE) || ov_q || sts.clearing;
	assign tbl_we = take && (in_kind == KIND_LOAD);
	assign out_valid = ov_q;
	assign action = act_q;
	assign new_weight = w_q;
	assign last = last_q;

	// Next state and command decode.
	always_comb begin
		st_d = st_q;
		cmd = '0;
		emit = 1'b0;
		e_act = ACT_SAME;
		e_w = weight_in;
		e_last = 1'b1;
		unique case (st_q)
			S_IDLE: begin
				if (take) begin
					cmd.capture = 1'b1;
					if (in_kind == KIND_CROSS) st_d = S_IDX;
					else if (in_kind != KIND_LOAD) st_d = S_WAIT;
				end
			end
			S_WAIT: begin
				emit = 1'b1;
				st_d = S_IDLE;
			end
			S_IDX: begin cmd.idx_calc = 1'b1; st_d = S_RDP; end
			S_RDP: begin cmd.rd_pre = 1'b1; st_d = S_RDQ; end
			S_RDQ: begin cmd.rd_post = 1'b1; cmd.lat_pre = 1'b1; st_d = S_LATQ; end
			S_LATQ: begin cmd.lat_post = 1'b1; st_d = S_DEC; end
			S_DEC: begin
				cmd.mul_start = 1'b1;
				if (sts.pre_zero) begin
					emit = 1'b1; st_d = S_IDLE;
				end else if (sts.post_gt) begin
					cmd.div_start = 1'b1; cmd.div_sel = DIV_RATIO; st_d = S_DIVR;
				end else begin
					st_d = S_DIVW;
				end
			end
			S_DIVR: begin
				cmd.div_sel = DIV_RATIO;
				if (sts.div_done) begin cmd.lat_n = 1'b1; st_d = S_DIVS; end
			end
			S_DIVS: begin
				cmd.div_sel = DIV_SPLIT;
				if (cnt_q == 7'd0) cmd.div_start = 1'b1;
				else if (sts.div_done) begin cmd.lat_w = 1'b1; st_d = S_EMIT; end
			end
			S_DIVW: begin
				cmd.div_sel = DIV_SURV;
				if (cnt_q == 7'd0) begin
					if (sts.kill) begin
						emit = 1'b1; e_act = ACT_KILL; e_w = '0; st_d = S_IDLE;
					end else if (sts.post_zero) begin
						emit = 1'b1; e_act = ACT_PARENT; e_w = '1; st_d = S_IDLE;
					end else cmd.div_start = 1'b1;
				end else if (sts.div_done) begin
					cmd.lat_w = 1'b1; st_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (o_free) begin
					emit = 1'b1;
					e_w = res_w;
					if (cnt_q == 7'd0) e_act = ACT_PARENT;
					else e_act = ACT_COPY;
					e_last = (cnt_q + 7'd1 >= split_n);
					if (e_last) st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
		if ((st_q == S_WAIT || st_q == S_DEC || st_q == S_DIVW) && !o_free) begin
			emit = 1'b0;
		end
	end

	// State, sub-step counter and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= 7'd0;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q != st_d) cnt_q <= 7'd0;
			else if (st_q == S_DIVS || st_q == S_DIVW || (st_q == S_EMIT && emit))
				cnt_q <= cnt_q + 7'd1;
			if (emit) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			act_q <= e_act;
			w_q <= e_w;
			last_q <= e_last;
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/voxel_importance_split_roulette.sv
// Channel | handshake           | payload
// in      | in_valid/in_stall   | kind ... random
// out     | out_valid/out_stall | action, new_weight, last
// cfg     | APB                 | count_y (0x0), count_z (0x4)
// A load is written into the table as it is taken; another kind gives its word via a wait state.
// A crossing reads both table entries, then gives its first word with no divider pass
// for zero pre importance, a kill or zero post, after one divider pass for a survivor and
// after two passes for a split, then one word per cycle for the split copies while out is not stalled.
// After reset the table is cleared one entry a cycle, all TABLE_DEPTH entries in turn.
// The input stalls during clearing, while an item is in work or a word waits.
`default_nettype none
module voxel_importance_split_roulette import visr_pkg::*; #(
	parameter int TABLE_DEPTH = 4096,
	parameter int MAX_SPLIT = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] kind,
	input wire logic [11:0] entry_index,
	input wire logic [31:0] entry_value,
	input wire logic [5:0] pre_x,
	input wire logic [5:0] pre_y,
	input wire logic [5:0] pre_z,
	input wire logic [5:0] post_x,
	input wire logic [5:0] post_y,
	input wire logic [5:0] post_z,
	input wire logic [31:0] weight,
	input wire logic [23:0] random,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] action,
	output logic [31:0] new_weight,
	output logic last
);
	logic [6:0] cy_q, cz_q;
	visr_cmd_t cmd;
	visr_sts_t sts;
	logic [6:0] split_n;
	logic [31:0] weight_in, res_w;
	logic tbl_we;

	assign pready = 1'b1;

	// Register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cy_q <= 7'd1;
			cz_q <= 7'd1;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
			if (paddr[2] == REG_COUNT_Y) cy_q <= pwdata[6:0];
			else cz_q <= pwdata[6:0];
		end
	end

	assign prdata = (paddr[2] == REG_COUNT_Y) ? {25'd0, cy_q} : {25'd0, cz_q};

	visr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_kind(kind), .cmd(cmd), .sts(sts), .split_n(split_n),
		.weight_in(weight_in), .res_w(res_w), .tbl_we(tbl_we),
		.out_valid(out_valid), .out_stall(out_stall), .action(action),
		.new_weight(new_weight), .last(last)
	);

	visr_dp #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_SPLIT(MAX_SPLIT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .cy(cy_q), .cz(cz_q),
		.tbl_we(tbl_we), .entry_index(entry_index), .entry_value(entry_value),
		.pre_x(pre_x), .pre_y(pre_y), .pre_z(pre_z),
		.post_x(post_x), .post_y(post_y), .post_z(post_z),
		.weight(weight), .random(random), .split_n(split_n),
		.weight_in(weight_in), .res_w(res_w)
	);
endmodule
`default_nettype wire

>>> rtl/core/visr_checker.sv
// Port-level checker for the split and roulette block, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module visr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [1:0] action,
	input wire logic [31:0] new_weight,
	input wire logic last
);
	// A stalled word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(new_weight))
		else $error("output word changed under stall");
	// A killed track carries zero weight.
	a_kill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == 2'd2 |-> new_weight == 32'd0 && last)
		else $error("kill word malformed");
	// Unchanged results are single words.
	a_same: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == 2'd0 |-> last)
		else $error("unchanged word not last");
	// No input is taken while a word is waiting.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken during output");
endmodule

bind voxel_importance_split_roulette visr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .action(action),
	.new_weight(new_weight), .last(last)
);
`default_nettype wire
